>>> src/mrd_pkg.sv
`timescale 1ns / 1ps

package mrd_pkg;

    // Fixed bytes of the reply report
    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] MARK_BYTE   = 8'hA5;
    localparam logic [7:0] CMD_BAT     = 8'h30;
    localparam logic [7:0] CMD_RES     = 8'h0E;
    localparam logic [7:0] LEN_BAT     = 8'h0A;
    localparam logic [7:0] LEN_RES     = 8'h2E;
    localparam logic [7:0] ONE_BYTE    = 8'h01;
    localparam logic [7:0] BAT_MAX_PCT = 8'd100;

    // Byte positions within the report
    localparam int POS_SYNC   = 0;
    localparam int POS_CMD    = 1;
    localparam int POS_MARK   = 2;
    localparam int POS_LEN    = 4;
    localparam int POS_ONE_LO = 5;
    localparam int POS_ONE_HI = 7;
    localparam int POS_PCT    = 8;
    localparam int POS_COUNT  = 11;
    localparam int POS_ACTIVE = 12;
    localparam int POS_STAGE0 = 13;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DPI_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DPI_MAX = 1'b1;
    localparam logic [15:0] DPI_MIN_RST = 16'd50;
    localparam logic [15:0] DPI_MAX_RST = 16'd50000;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RES  = 2'd1,
        KIND_BAT  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_RES    = 2'd1,
        ST_BAT    = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] reading;
    } t_result;

endpackage

>>> src/mrd_core.sv
`timescale 1ns / 1ps

module mrd_core
    import mrd_pkg::*;
#(
    parameter int REPORT_BYTES = 64,
    parameter int MAX_STAGES   = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_dpi_min,
    input  logic [15:0] i_dpi_max,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam int IDX_W = $clog2(REPORT_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_STAGES + 1);
    localparam int POS_W = IDX_W + 1;

    logic [IDX_W-1:0] r_idx,      n_idx;
    logic             r_overlong, n_overlong;
    logic             r_ok,       n_ok;
    t_kind            r_kind,     n_kind;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [CNT_W-1:0] r_active,   n_active;
    logic [7:0]       r_low,      n_low;
    logic [15:0]      r_pick,     n_pick;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] stage_end;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] stage_num;
    logic             in_stages;
    logic [15:0]      value;
    logic             pass;

    assign pos       = POS_W'(r_idx);
    assign stage_end = POS_W'(POS_STAGE0) + POS_W'({r_count, 1'b0});
    assign off       = pos - POS_W'(POS_STAGE0);
    assign stage_num = POS_W'(off[POS_W-1:1]) + POS_W'(1);
    assign in_stages = (pos >= POS_W'(POS_STAGE0)) && (pos < stage_end);
    assign value     = {i_byte, r_low};

    always_comb begin
        n_idx      = r_idx;
        n_overlong = r_overlong;
        n_ok       = r_ok;
        n_kind     = r_kind;
        n_count    = r_count;
        n_active   = r_active;
        n_low      = r_low;
        n_pick     = r_pick;
        pass       = 1'b0;
        o_res      = '{status: ST_REJECT, reading: 16'd0};

        if (i_step) begin
            if (pos >= POS_W'(REPORT_BYTES)) begin
                n_overlong = 1'b1;
            end else begin
                n_idx = r_idx + IDX_W'(1);
                if (pos == POS_W'(POS_SYNC)) begin
                    if (i_byte != SYNC_BYTE) n_ok = 1'b0;
                end else if (pos == POS_W'(POS_CMD)) begin
                    if (i_byte == CMD_BAT) begin
                        n_kind = KIND_BAT;
                    end else if (i_byte == CMD_RES) begin
                        n_kind = KIND_RES;
                    end else begin
                        n_kind = KIND_NONE;
                        n_ok   = 1'b0;
                    end
                end else if (pos == POS_W'(POS_MARK)) begin
                    if (i_byte != MARK_BYTE) n_ok = 1'b0;
                end else if (pos == POS_W'(POS_LEN)) begin
                    if (r_kind == KIND_BAT && i_byte != LEN_BAT) n_ok = 1'b0;
                    if (r_kind == KIND_RES && i_byte != LEN_RES) n_ok = 1'b0;
                end else if (pos >= POS_W'(POS_ONE_LO) && pos <= POS_W'(POS_ONE_HI)) begin
                    if (i_byte != ONE_BYTE) n_ok = 1'b0;
                end else if (r_kind == KIND_BAT) begin
                    if (pos == POS_W'(POS_PCT)) begin
                        if (i_byte > BAT_MAX_PCT) n_ok = 1'b0;
                        n_pick = {8'd0, i_byte};
                    end
                end else if (r_kind == KIND_RES) begin
                    if (pos == POS_W'(POS_COUNT)) begin
                        // An out-of-range count already fails the report, so a zero
                        // count is kept and no stage bytes are examined.
                        if (i_byte == 8'd0 || i_byte > 8'(MAX_STAGES)) begin
                            n_ok    = 1'b0;
                            n_count = '0;
                        end else begin
                            n_count = i_byte[CNT_W-1:0];
                        end
                    end else if (pos == POS_W'(POS_ACTIVE)) begin
                        n_active = i_byte[CNT_W-1:0];
                        if (i_byte == 8'd0 || i_byte > 8'(r_count)) n_ok = 1'b0;
                    end else if (in_stages) begin
                        if (!off[0]) begin
                            n_low = i_byte;
                        end else begin
                            if (value < i_dpi_min || value > i_dpi_max) n_ok = 1'b0;
                            if (stage_num == POS_W'(r_active)) n_pick = value;
                        end
                    end
                end
            end

            if (i_last) begin
                pass = n_ok && !n_overlong && (pos == POS_W'(REPORT_BYTES - 1))
                       && (n_kind != KIND_NONE);
                if (pass) begin
                    case (n_kind)
                        KIND_RES: o_res.status = ST_RES;
                        KIND_BAT: o_res.status = ST_BAT;
                        default:  o_res.status = ST_REJECT;
                    endcase
                    o_res.reading = n_pick;
                end
                n_idx      = '0;
                n_overlong = 1'b0;
                n_ok       = 1'b1;
                n_kind     = KIND_NONE;
                n_count    = '0;
                n_active   = '0;
                n_low      = '0;
                n_pick     = '0;
            end
        end
    end

    assign o_res_valid = i_step && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_overlong <= 1'b0;
            r_ok       <= 1'b1;
            r_kind     <= KIND_NONE;
            r_count    <= '0;
            r_active   <= '0;
            r_low      <= '0;
            r_pick     <= '0;
        end else begin
            r_idx      <= n_idx;
            r_overlong <= n_overlong;
            r_ok       <= n_ok;
            r_kind     <= n_kind;
            r_count    <= n_count;
            r_active   <= n_active;
            r_low      <= n_low;
            r_pick     <= n_pick;
        end
    end

endmodule

>>> src/mouse_report_decoder.sv
`timescale 1ns / 1ps
// Channel     Direction  Handshake                        Payload
// s_axis      in         i_s_axis_tvalid/o_s_axis_tready  tdata = data_byte, tlast = last_byte
// m_axis      out        o_m_axis_tvalid/i_m_axis_tready  tdata = reading, tuser = status
// cfg         in         i_cfg_valid/o_cfg_ready          index 0 dpi_min, 1 dpi_max
//
// One word per cycle is taken while the input is not stalled; each word passes an input
// register, then the check logic updates the report state and, on the last word, loads
// the result register, from which the result is offered.
// Reset is synchronous and active low; it restores the bounds to 50 and 50000.
// While a result waits in the output register, non-final words still flow;
// only a second final word stalls the input.

module mouse_report_decoder
    import mrd_pkg::*;
#(
    parameter int REPORT_BYTES = 64,
    parameter int MAX_STAGES   = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,   // [7:0] data_byte
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // [15:0] reading
    output logic [1:0]           o_m_axis_tuser,   // [1:0] status
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [15:0] r_dpi_min;
    logic [15:0] r_dpi_max;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic        r_out_valid;
    t_result     r_out;

    logic        advance;
    logic        step;
    logic        res_valid;
    t_result     res;

    // The input word moves on unless it is final and the result register is full and not being taken.
    assign advance = !r_in_valid || !r_in_last || !r_out_valid || i_m_axis_tready;
    assign step    = r_in_valid && advance;

    assign o_s_axis_tready = advance;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpi_min <= DPI_MIN_RST;
            r_dpi_max <= DPI_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DPI_MIN: r_dpi_min <= i_cfg_data;
                CFG_DPI_MAX: r_dpi_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    mrd_core #(
        .REPORT_BYTES (REPORT_BYTES),
        .MAX_STAGES   (MAX_STAGES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_dpi_min   (r_dpi_min),
        .i_dpi_max   (r_dpi_max),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.reading;
    assign o_m_axis_tuser  = r_out.status;

endmodule

>>> src/mrd_checker.sv
`timescale 1ns / 1ps

module mrd_checker
    import mrd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [15:0]          o_m_axis_tdata,
    input logic [1:0]           o_m_axis_tuser
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A rejected report always carries a zero reading.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_REJECT |-> o_m_axis_tdata == 16'd0)
        else $error("rejected report with nonzero reading");

    // A battery reply never reports more than the full percentage.
    a_bat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_BAT |-> o_m_axis_tdata <= {8'd0, BAT_MAX_PCT})
        else $error("battery reading out of range");

    // The input side is ready right after reset.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind mouse_report_decoder mrd_checker u_mrd_checker (.*);
